// File: rtl/rsc_pkg.sv
// ----------------------------------------------------------------------------
// RPN calculator package
// Shared constants, status and command codes, and fixed-point helpers.
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int STACK_DEPTH = 4;
  localparam int FRAC_BITS   = 16;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int PROD_W      = 2 * DATA_W;

  localparam int DVD_W       = DATA_W + FRAC_BITS;
  localparam int RADIX_BITS  = 2;
  localparam int DIV_CYC     = (DVD_W + RADIX_BITS - 1) / RADIX_BITS;
  localparam int DVD_PAD_W   = RADIX_BITS * DIV_CYC;
  localparam int DIV_CNT_W   = $clog2(DIV_CYC + 1);

  localparam logic [DATA_W-1:0] MINUS_ONE = DATA_W'(0) - (DATA_W'(1) << FRAC_BITS);
  localparam logic [DATA_W-1:0] SAT_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN   = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [PROD_W-1:0] SAT_LIM   = PROD_W'(1) << (DATA_W - 1);

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_APPLY  = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_UNDER = 3'd2;
  localparam logic [2:0] ST_DIVZ  = 3'd3;
  localparam logic [2:0] ST_BADOP = 3'd4;
  localparam logic [2:0] ST_IGN   = 3'd5;
  localparam logic [2:0] ST_RES   = 3'd6;
  localparam logic [2:0] ST_NORES = 3'd7;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LEFT,
    CELL_RIGHT
  } cell_op_t;

  function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? DATA_W'(0) - v : v;
  endfunction

  function automatic logic [DATA_W-1:0] saturate(input logic neg,
                                                 input logic [PROD_W-1:0] mag);
    logic [DATA_W-1:0] res;
    if (neg) begin
      res = (mag >= SAT_LIM) ? SAT_MIN : DATA_W'(0) - mag[DATA_W-1:0];
    end else begin
      res = (mag >= SAT_LIM) ? SAT_MAX : mag[DATA_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: rtl/rpn_stack_calculator.sv
// ----------------------------------------------------------------------------
// RPN stack calculator
// Reverse Polish evaluator over a chain of stack cells, Q16.16 arithmetic.
// Push, finish and ignored tokens pass through execute and write; add/subtract
// adds an apply step, aborts a pop step; multiply and divide add a step before apply.
// One token at a time; the next is taken the cycle after the result is
// registered, so a divide holds the block until the radix-4 divider is done.
// Synchronous active-high reset empties the stack and clears the abort flag.
// ----------------------------------------------------------------------------
module rpn_stack_calculator import rsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // number_value[31:0], operator_code[34:32]
  input  logic [1:0]  s_tuser,   // command[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // result_value[31:0], stack_count[34:32]
  output logic [2:0]  m_tuser    // status[2:0]
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;
  localparam logic [2:0] S_POP   = 3'd5;
  localparam logic [2:0] S_WRITE = 3'd6;

  logic [2:0]           state;
  logic [CNT_W-1:0]     count;
  logic                 aborted;

  logic [1:0]           tok_cmd;
  logic [DATA_W-1:0]    tok_num;
  logic [2:0]           tok_op;
  logic                 ok_r;
  logic                 neg;
  logic                 fin;
  logic [PROD_W-1:0]    prod;
  logic [DATA_W-1:0]    r_val;
  logic [2:0]           res_status;

  logic [DATA_W-1:0]    cells [STACK_DEPTH];
  cell_op_t             cell_ops [STACK_DEPTH];
  logic [DATA_W-1:0]    load_data;

  logic [DATA_W-1:0]    opa;
  logic [DATA_W-1:0]    opb;
  logic                 exec_op;
  logic                 exec_push;
  logic                 exec_abort;
  logic                 div_start;
  logic                 div_done;
  logic [DVD_PAD_W-1:0] div_quo;
  logic                 push_en;
  logic                 pop_en;
  logic                 apply_en;
  logic                 out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  assign opb = (count != '0) ? cells[0] : MINUS_ONE;
  assign opa = (count >= CNT_W'(2)) ? cells[1] : MINUS_ONE;

  assign exec_op    = (state == S_EXEC) && (tok_cmd == CMD_APPLY) && !aborted;
  assign exec_push  = (state == S_EXEC) && (tok_cmd == CMD_PUSH) && !aborted &&
                      (count < CNT_W'(STACK_DEPTH));
  assign exec_abort = exec_op && ((tok_op == OP_DIV && opb == '0) || tok_op > OP_DIV);
  assign div_start  = exec_op && (tok_op == OP_DIV) && (opb != '0);

  assign push_en  = exec_push;
  assign pop_en   = exec_abort || (state == S_POP);
  assign apply_en = (state == S_APPLY);
  assign load_data = apply_en ? r_val : tok_num;

  always_comb begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      if (push_en) begin
        cell_ops[i] = CELL_LEFT;
      end else if (pop_en) begin
        cell_ops[i] = CELL_RIGHT;
      end else if (apply_en) begin
        cell_ops[i] = (i == 0) ? CELL_LEFT : CELL_RIGHT;
      end else begin
        cell_ops[i] = CELL_HOLD;
      end
    end
  end

  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    rsc_cell u_cell (
      .clk        (clk),
      .op         (cell_ops[g]),
      .left_data  ((g == 0) ? load_data : cells[(g == 0) ? 0 : g - 1]),
      .right_data (cells[(g == STACK_DEPTH - 1) ? g : g + 1]),
      .data       (cells[g])
    );
  end

  rsc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({magnitude(opa), {FRAC_BITS{1'b0}}}),
    .divisor  (magnitude(opb)),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      aborted  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_WRITE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_push) begin
            count <= count + CNT_W'(1);
          end
          if (exec_abort) begin
            aborted <= 1'b1;
            count   <= (count != '0) ? count - CNT_W'(1) : '0;
            state   <= S_POP;
          end else if (exec_op) begin
            if (tok_op == OP_MUL) begin
              state <= S_MUL;
            end else if (tok_op == OP_DIV) begin
              state <= S_DIV;
            end else begin
              state <= S_APPLY;
            end
          end else begin
            state <= S_WRITE;
          end
        end
        S_MUL: begin
          state <= S_APPLY;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          count <= ((count >= CNT_W'(2)) ? count - CNT_W'(2) : '0) + CNT_W'(1);
          state <= S_WRITE;
        end
        S_POP: begin
          count <= (count != '0) ? count - CNT_W'(1) : '0;
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (out_free) begin
            if (fin) begin
              count   <= '0;
              aborted <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      tok_cmd <= s_tuser;
      tok_num <= s_tdata[DATA_W-1:0];
      tok_op  <= s_tdata[DATA_W+2:DATA_W];
    end
    if (state == S_EXEC) begin
      fin   <= (tok_cmd == CMD_FINISH);
      ok_r  <= (count >= CNT_W'(2));
      neg   <= opa[DATA_W-1] ^ opb[DATA_W-1];
      prod  <= PROD_W'(magnitude(opa)) * PROD_W'(magnitude(opb));
      r_val <= (tok_op == OP_SUB) ? opa - opb : opa + opb;
      if (tok_cmd == CMD_FINISH) begin
        res_status <= (count != '0 && !aborted) ? ST_RES : ST_NORES;
      end else if (aborted || (tok_cmd != CMD_PUSH && tok_cmd != CMD_APPLY)) begin
        res_status <= ST_IGN;
      end else if (tok_cmd == CMD_PUSH) begin
        res_status <= exec_push ? ST_OK : ST_FULL;
      end else if (tok_op == OP_DIV && opb == '0) begin
        res_status <= ST_DIVZ;
      end else if (tok_op > OP_DIV) begin
        res_status <= ST_BADOP;
      end
    end
    if (state == S_MUL) begin
      r_val <= saturate(neg, prod >> FRAC_BITS);
    end
    if (state == S_DIV && div_done) begin
      r_val <= saturate(neg, PROD_W'(div_quo));
    end
    if (state == S_APPLY) begin
      res_status <= ok_r ? ST_OK : ST_UNDER;
    end
    if (state == S_WRITE && out_free) begin
      m_tuser <= res_status;
      if (fin) begin
        m_tdata <= {5'b0, 3'b0, (res_status == ST_RES) ? cells[0] : DATA_W'(0)};
      end else begin
        m_tdata <= {5'b0, 3'(count), (count != '0) ? cells[0] : DATA_W'(0)};
      end
    end
  end

endmodule

// File: rtl/rsc_cell.sv
// ----------------------------------------------------------------------------
// RPN calculator stack cell
// One stack level; takes its upper or lower neighbor's entry, or holds.
// ----------------------------------------------------------------------------
module rsc_cell import rsc_pkg::*; (
  input  logic              clk,
  input  cell_op_t          op,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] data
);

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_LEFT:  data <= left_data;
      CELL_RIGHT: data <= right_data;
      default:    data <= data;
    endcase
  end

endmodule

// File: rtl/rsc_divider.sv
// ----------------------------------------------------------------------------
// RPN calculator divider
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module rsc_divider import rsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DVD_W-1:0]     dividend,
  input  logic [DATA_W-1:0]    divisor,
  output logic                 done,
  output logic [DVD_PAD_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    dsr;
  logic [DVD_PAD_W-1:0] dvd;
  logic [DATA_W-1:0]    rem_next;
  logic [DVD_PAD_W-1:0] dvd_next;

  always_comb begin
    logic [DATA_W:0] trial;
    logic            qbit;
    rem_next = rem;
    dvd_next = dvd;
    for (int k = 0; k < RADIX_BITS; k++) begin
      trial = {rem_next, dvd_next[DVD_PAD_W-1]};
      if (trial >= {1'b0, dsr}) begin
        trial = trial - {1'b0, dsr};
        qbit  = 1'b1;
      end else begin
        qbit  = 1'b0;
      end
      rem_next = trial[DATA_W-1:0];
      dvd_next = {dvd_next[DVD_PAD_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_CYC);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= DVD_PAD_W'(dividend);
      dsr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= dvd_next;
    end
  end

  assign quotient = dvd;

endmodule

// File: rtl/rsc_checker.sv
// ----------------------------------------------------------------------------
// RPN calculator port checker
// Checks result transactions on the top-level ports.
// ----------------------------------------------------------------------------
module rsc_checker import rsc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [2:0]  m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result transaction changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[34:32] <= 3'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_finish_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_RES || m_tuser == ST_NORES) |-> m_tdata[34:32] == 3'd0)
    else $error("finish left entries on stack");

  a_nores_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_NORES |-> m_tdata[31:0] == 32'd0)
    else $error("no-result transaction carries a value");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_FULL |-> m_tdata[34:32] == 3'(STACK_DEPTH))
    else $error("full drop on a stack that is not full");

endmodule

bind rpn_stack_calculator rsc_checker u_rsc_checker (.*);
